// ===== sv/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types, codes and constants for the cartridge bank controller.
// ----------------------------------------------------------------------------
package cbc_pkg;

  // Controller kinds
  localparam logic [1:0] KIND_ROM_ONLY = 2'd0;
  localparam logic [1:0] KIND_MBC1     = 2'd1;
  localparam logic [1:0] KIND_MBC2     = 2'd2;
  localparam logic [1:0] KIND_MBC3     = 2'd3;

  // Result targets
  localparam logic [2:0] TGT_FIXED_ROM  = 3'd0;
  localparam logic [2:0] TGT_BANKED_ROM = 3'd1;
  localparam logic [2:0] TGT_CART_RAM   = 3'd2;
  localparam logic [2:0] TGT_RTC        = 3'd3;
  localparam logic [2:0] TGT_CTRL       = 3'd4;
  localparam logic [2:0] TGT_NONE       = 3'd5;

  // Control write regions, address bits 14:13 below 0x8000
  localparam logic [1:0] REGION_ENABLE   = 2'd0;
  localparam logic [1:0] REGION_ROM_BANK = 2'd1;
  localparam logic [1:0] REGION_RAM_BANK = 2'd2;
  localparam logic [1:0] REGION_MODE     = 2'd3;

  // RTC latch sequence
  localparam logic [1:0] LATCH_IDLE    = 2'd0;
  localparam logic [1:0] LATCH_ARMED   = 2'd1;
  localparam logic [1:0] LATCH_HELD    = 2'd2;
  localparam logic [1:0] LATCH_REARMED = 2'd3;

  // RAM window select 0xA000-0xBFFF: address bits 15:13
  localparam logic [2:0] RAM_WINDOW_TAG = 3'b101;

  localparam int ROM_BANK_BYTES = 16384;
  localparam int ROM_OFF_BITS   = $clog2(ROM_BANK_BYTES);
  localparam int ROM_BANK_BITS  = 7;
  localparam int ROM_ADDR_BITS  = 21;
  localparam int RAM_ADDR_BITS  = 15;

  localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
  localparam logic [3:0] RTC_SEL_FIRST  = 4'h8;
  localparam logic [3:0] RTC_SEL_LAST   = 4'hC;

  typedef struct packed {
    logic        action;
    logic [15:0] address;
    logic [7:0]  write_data;
  } access_t;

  typedef struct packed {
    logic [ROM_BANK_BITS-1:0] rom_bank;
    logic [3:0]               ram_bank;
    logic                     ram_enable;
    logic                     banking_mode;
    logic [1:0]               latch_seq;
  } bank_state_t;

  localparam bank_state_t BANK_STATE_RESET = '{
    rom_bank:     7'd1,
    ram_bank:     4'd0,
    ram_enable:   1'b0,
    banking_mode: 1'b0,
    latch_seq:    LATCH_IDLE
  };

  typedef struct packed {
    logic [2:0]               target;
    logic [ROM_ADDR_BITS-1:0] rom_address;
    logic [RAM_ADDR_BITS-1:0] ram_address;
    logic [2:0]               rtc_index;
    logic [7:0]               store_data;
    logic                     ram_enabled;
    logic                     rtc_held;
  } result_t;

  function automatic logic enable_value(input logic [7:0] data);
    return data[3:0] == RAM_ENABLE_KEY;
  endfunction

endpackage

// ===== sv/cbc_access_if.sv =====
// ----------------------------------------------------------------------------
// cbc_access_if
// Valid/ready channel carrying one CPU bus access to the cartridge space.
// ----------------------------------------------------------------------------
interface cbc_access_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, output action, output address, output write_data,
                  input ready);
  modport sink   (input valid, input action, input address, input write_data,
                  output ready);
endinterface

// ===== sv/cbc_result_if.sv =====
// ----------------------------------------------------------------------------
// cbc_result_if
// Valid/ready channel carrying one translated access result.
// ----------------------------------------------------------------------------
interface cbc_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  target;
  logic [20:0] rom_address;
  logic [14:0] ram_address;
  logic [2:0]  rtc_index;
  logic [7:0]  store_data;
  logic        ram_enabled;
  logic        rtc_held;

  modport source (output valid, output target, output rom_address, output ram_address,
                  output rtc_index, output store_data, output ram_enabled,
                  output rtc_held, input ready);
  modport sink   (input valid, input target, input rom_address, input ram_address,
                  input rtc_index, input store_data, input ram_enabled,
                  input rtc_held, output ready);
endinterface

// ===== sv/cbc_bank_regs.sv =====
// ----------------------------------------------------------------------------
// cbc_bank_regs
// Controller kind, bank registers and RTC latch sequence, with the control
// write decode for each controller kind.
// ----------------------------------------------------------------------------
module cbc_bank_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [1:0]          cfg_write_data,
  input  logic                update,
  input  cbc_pkg::access_t    item,
  output logic [1:0]          kind,
  output cbc_pkg::bank_state_t state,
  output cbc_pkg::bank_state_t state_next,
  output logic [2:0]          ctrl_target
);
  import cbc_pkg::*;

  logic [1:0] region;
  logic [7:0] data;
  logic [4:0] low5;
  logic       sel_ok;

  assign region = item.address[14:13];
  assign data   = item.write_data;
  assign low5   = data[4:0];
  assign sel_ok = (data < 8'h04) ||
                  (data >= {4'h0, RTC_SEL_FIRST} && data <= {4'h0, RTC_SEL_LAST});

  always_comb begin
    state_next  = state;
    ctrl_target = TGT_NONE;
    if (item.action && !item.address[15]) begin
      case (kind)
        KIND_MBC1: begin
          ctrl_target = TGT_CTRL;
          case (region)
            REGION_ENABLE: state_next.ram_enable = enable_value(data);
            REGION_ROM_BANK: begin
              // bank zero of the low field reads as bank one
              if (low5 == 5'd0) begin
                state_next.rom_bank = {state.rom_bank[6:5], 5'd1};
              end else begin
                state_next.rom_bank = {state.rom_bank[6:5], low5};
              end
            end
            REGION_RAM_BANK: begin
              if (!state.banking_mode) begin
                state_next.rom_bank = {data[1:0], state.rom_bank[4:0]};
              end else begin
                state_next.ram_bank = {2'b00, data[1:0]};
              end
            end
            default: begin
              state_next.banking_mode = data[0];
              if (!data[0]) begin
                state_next.ram_bank = 4'd0;
              end else begin
                state_next.rom_bank = {2'b00, state.rom_bank[4:0]};
              end
            end
          endcase
        end
        KIND_MBC2: begin
          // address bit 8 picks enable versus bank register
          case (region)
            REGION_ENABLE: begin
              if (!item.address[8]) begin
                state_next.ram_enable = enable_value(data);
                ctrl_target           = TGT_CTRL;
              end
            end
            REGION_ROM_BANK: begin
              if (item.address[8]) begin
                state_next.rom_bank = (data[3:0] == 4'd0) ? 7'd1 : {3'b000, data[3:0]};
                ctrl_target         = TGT_CTRL;
              end
            end
            default: ctrl_target = TGT_NONE;
          endcase
        end
        KIND_MBC3: begin
          ctrl_target = TGT_CTRL;
          case (region)
            REGION_ENABLE: state_next.ram_enable = enable_value(data);
            REGION_ROM_BANK: begin
              state_next.rom_bank = (data[6:0] == 7'd0) ? 7'd1 : data[6:0];
            end
            REGION_RAM_BANK: begin
              if (sel_ok) begin
                state_next.ram_bank = data[3:0];
              end
            end
            default: begin
              case (state.latch_seq)
                LATCH_IDLE:  state_next.latch_seq = (data == 8'h00) ? LATCH_ARMED : LATCH_IDLE;
                LATCH_ARMED: state_next.latch_seq = (data == 8'h01) ? LATCH_HELD : LATCH_IDLE;
                LATCH_HELD:  state_next.latch_seq = (data == 8'h00) ? LATCH_REARMED : LATCH_HELD;
                default:     state_next.latch_seq = LATCH_HELD;
              endcase
            end
          endcase
        end
        default: ctrl_target = TGT_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind  <= KIND_ROM_ONLY;
      state <= BANK_STATE_RESET;
    end else begin
      if (cfg_write_en) begin
        kind <= cfg_write_data;
      end
      if (update) begin
        state <= state_next;
      end
    end
  end

endmodule

// ===== sv/cbc_addr_map.sv =====
// ----------------------------------------------------------------------------
// cbc_addr_map
// Translates one access into a ROM address, cart RAM address or RTC index,
// using bank registers before the access and enable/latch flags after it.
// ----------------------------------------------------------------------------
module cbc_addr_map #(
  parameter int RAM_BANK_BYTES = 8192
) (
  input  logic [1:0]           kind,
  input  cbc_pkg::access_t     item,
  input  cbc_pkg::bank_state_t state,
  input  cbc_pkg::bank_state_t state_next,
  input  logic [2:0]           ctrl_target,
  output cbc_pkg::result_t     res
);
  import cbc_pkg::*;

  // bank size is a power of two, so the window offset is a bit field
  localparam int RAM_OFF_BITS = $clog2(RAM_BANK_BYTES);

  logic [ROM_BANK_BITS-1:0] rom_bank;
  logic [1:0]               ram_bank;
  logic [2:0]               ram_target;
  logic [3:0]               sel;

  assign sel      = state.ram_bank;
  assign rom_bank = (kind == KIND_ROM_ONLY) ? 7'd1 : state.rom_bank;

  always_comb begin
    ram_bank   = 2'd0;
    ram_target = TGT_CART_RAM;
    case (kind)
      KIND_MBC1: ram_bank = sel[1:0];
      KIND_MBC3: begin
        if (sel[3:2] == 2'b00) begin
          ram_bank = sel[1:0];
        end else if (sel >= RTC_SEL_FIRST && sel <= RTC_SEL_LAST) begin
          ram_target = TGT_RTC;
        end else begin
          ram_target = TGT_NONE;
        end
      end
      default: ram_bank = 2'd0;
    endcase
  end

  always_comb begin
    res             = '0;
    res.target      = TGT_NONE;
    res.ram_enabled = state_next.ram_enable;
    res.rtc_held    = state_next.latch_seq[1];
    if (!item.address[15]) begin
      if (item.action) begin
        res.target = ctrl_target;
      end else if (!item.address[14]) begin
        res.target      = TGT_FIXED_ROM;
        res.rom_address = ROM_ADDR_BITS'(item.address[ROM_OFF_BITS-1:0]);
      end else begin
        res.target      = TGT_BANKED_ROM;
        res.rom_address = {rom_bank, item.address[ROM_OFF_BITS-1:0]};
      end
    end else if (item.address[15:13] == RAM_WINDOW_TAG) begin
      res.target = ram_target;
      if (ram_target == TGT_CART_RAM) begin
        res.ram_address = RAM_ADDR_BITS'({ram_bank, item.address[RAM_OFF_BITS-1:0]});
      end
      if (ram_target == TGT_RTC) begin
        // select 8..12 minus 8 is its low three bits
        res.rtc_index = sel[2:0];
      end
      if (item.action && (ram_target == TGT_CART_RAM || ram_target == TGT_RTC)) begin
        res.store_data = (kind == KIND_MBC2) ? {4'h0, item.write_data[3:0]}
                                             : item.write_data;
      end
    end
  end

endmodule

// ===== sv/cartridge_bank_controller.sv =====
// ----------------------------------------------------------------------------
// cartridge_bank_controller
// Cartridge memory bank controller: ROM only, MBC1, MBC2 and MBC3 banking
// rules with address translation for the ROM and cart RAM windows.
//
//   port             dir   kind          carries
//   access           in    valid/ready   action, address, write_data
//   result           out   valid/ready   target, addresses, rtc_index, store data, flags
//   cfg_write_en/_data in  write only    controller_kind
//
// One beat in, one beat out, one beat per cycle sustained while result is
// ready; an access beat passes the input register, then the result register.
// Bank state updates as the access moves from the input register into the
// result register, so back-to-back writes see each other in order.
// A stalled result holds the result register; the input register still
// takes a beat while the result register is free or draining.
// Reset is synchronous: bank state, controller kind and valids return to their reset values at once.
// ----------------------------------------------------------------------------
module cartridge_bank_controller #(
  parameter int RAM_BANK_BYTES = 8192
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [1:0]          cfg_write_data,
  cbc_access_if.sink          access,
  cbc_result_if.source        result
);
  import cbc_pkg::*;

  logic        stage_valid;
  access_t     stage_item;
  logic        advance;
  logic        res_valid;
  result_t     res_data;
  result_t     mapped;
  logic [1:0]  kind;
  bank_state_t bank_state;
  bank_state_t bank_state_next;
  logic [2:0]  ctrl_target;

  assign advance      = stage_valid && (!res_valid || result.ready);
  assign access.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (access.ready) begin
        stage_valid <= access.valid;
      end
      if (advance) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (access.valid && access.ready) begin
      stage_item <= '{action: access.action, address: access.address,
                      write_data: access.write_data};
    end
    if (advance) begin
      res_data <= mapped;
    end
  end

  cbc_bank_regs u_bank_regs (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .update         (advance),
    .item           (stage_item),
    .kind           (kind),
    .state          (bank_state),
    .state_next     (bank_state_next),
    .ctrl_target    (ctrl_target)
  );

  cbc_addr_map #(
    .RAM_BANK_BYTES (RAM_BANK_BYTES)
  ) u_addr_map (
    .kind        (kind),
    .item        (stage_item),
    .state       (bank_state),
    .state_next  (bank_state_next),
    .ctrl_target (ctrl_target),
    .res         (mapped)
  );

  assign result.valid       = res_valid;
  assign result.target      = res_data.target;
  assign result.rom_address = res_data.rom_address;
  assign result.ram_address = res_data.ram_address;
  assign result.rtc_index   = res_data.rtc_index;
  assign result.store_data  = res_data.store_data;
  assign result.ram_enabled = res_data.ram_enabled;
  assign result.rtc_held    = res_data.rtc_held;

`ifndef SYNTHESIS
  // an empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> access.ready)
    else $error("access stalled with empty result register");

  // bank state moves only with a beat leaving the input register
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(bank_state))
    else $error("bank state changed without an advancing beat");

  // no rule selects ROM bank zero from a bank value set under the same controller kind
  a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (rst)
    bank_state.rom_bank != '0)
    else $error("rom bank register reached zero");

  a_rom_addr_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.target != TGT_FIXED_ROM && res_data.target != TGT_BANKED_ROM
    |-> res_data.rom_address == '0)
    else $error("rom address set for a non-rom target");

  a_rtc_index_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.target == TGT_RTC |-> res_data.rtc_index <= 3'd4)
    else $error("rtc index out of range");
`endif

endmodule

// ===== bench/cartridge_bank_controller_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cartridge_bank_controller_tb
// Self-checking bench for the cartridge bank controller. A scoreboard class
// keeps its own copy of the bank registers and the controller kind. It works
// out the translated result of every access beat taken by the block, and
// compares each result beat against the oldest expected one. The run covers
// directed corner accesses for all four controller kinds. It then runs
// random access mixes under three idling profiles, with a kind change
// between each mix.
// ----------------------------------------------------------------------------
module cartridge_bank_controller_tb;
  import cbc_pkg::*;

  localparam int RAM_BYTES_PER_BANK = 8192;
  localparam int CYCLE_LIMIT        = 200000;
  localparam int DRAIN_CYCLES       = 4;

  class access_scoreboard;
    logic [1:0]  kind;
    logic [6:0]  rom_bank;
    logic [3:0]  ram_bank;
    logic        ram_en;
    logic        bank_mode;
    logic [1:0]  latch;
    result_t     expected_q[$];
    int          mismatches;
    int          checked;

    function new();
      kind       = KIND_ROM_ONLY;
      rom_bank   = 7'd1;
      ram_bank   = 4'd0;
      ram_en     = 1'b0;
      bank_mode  = 1'b0;
      latch      = LATCH_IDLE;
      mismatches = 0;
      checked    = 0;
    endfunction

    function logic [2:0] control_write(logic [15:0] adr, logic [7:0] dat);
      logic [1:0] region;
      region = adr[14:13];
      case (kind)
        KIND_MBC1: begin
          case (region)
            REGION_ENABLE: ram_en = (dat[3:0] == RAM_ENABLE_KEY);
            REGION_ROM_BANK: begin
              rom_bank = {rom_bank[6:5], dat[4:0]};
              if (dat[4:0] == 5'd0) rom_bank = rom_bank + 7'd1;
            end
            REGION_RAM_BANK: begin
              if (!bank_mode) rom_bank = {dat[1:0], rom_bank[4:0]};
              else ram_bank = {2'b00, dat[1:0]};
            end
            default: begin
              bank_mode = dat[0];
              if (!bank_mode) ram_bank = 4'd0;
              else rom_bank = {2'b00, rom_bank[4:0]};
            end
          endcase
          return TGT_CTRL;
        end
        KIND_MBC2: begin
          // address bit 8 picks between the enable and ROM bank registers
          if (region == REGION_ENABLE) begin
            if (adr[8]) return TGT_NONE;
            ram_en = (dat[3:0] == RAM_ENABLE_KEY);
            return TGT_CTRL;
          end
          if (region == REGION_ROM_BANK) begin
            if (!adr[8]) return TGT_NONE;
            rom_bank = {3'b000, dat[3:0]};
            if (dat[3:0] == 4'd0) rom_bank = 7'd1;
            return TGT_CTRL;
          end
          return TGT_NONE;
        end
        KIND_MBC3: begin
          case (region)
            REGION_ENABLE: ram_en = (dat[3:0] == RAM_ENABLE_KEY);
            REGION_ROM_BANK: begin
              rom_bank = dat[6:0];
              if (dat[6:0] == 7'd0) rom_bank = 7'd1;
            end
            REGION_RAM_BANK: begin
              // leave the select alone for values that are neither RAM nor RTC
              if (dat < 8'd4 || (dat >= 8'd8 && dat <= 8'(RTC_SEL_LAST)))
                ram_bank = dat[3:0];
            end
            default: begin
              case (latch)
                LATCH_IDLE:  latch = (dat == 8'h00) ? LATCH_ARMED : LATCH_IDLE;
                LATCH_ARMED: latch = (dat == 8'h01) ? LATCH_HELD : LATCH_IDLE;
                LATCH_HELD:  latch = (dat == 8'h00) ? LATCH_REARMED : LATCH_HELD;
                default:     latch = LATCH_HELD;
              endcase
            end
          endcase
          return TGT_CTRL;
        end
        default: return TGT_NONE;
      endcase
    endfunction

    function void note_access(access_t a);
      result_t     r;
      logic [6:0]  bank;
      logic [3:0]  sel;
      int unsigned offset;
      int unsigned ram_sel;
      r = '0;
      r.target = TGT_NONE;
      if (a.address < 16'h8000) begin
        if (a.action) begin
          r.target = control_write(a.address, a.write_data);
        end else if (a.address < 16'h4000) begin
          r.target      = TGT_FIXED_ROM;
          r.rom_address = 21'(a.address);
        end else begin
          bank          = (kind == KIND_ROM_ONLY) ? 7'd1 : rom_bank;
          r.target      = TGT_BANKED_ROM;
          r.rom_address = {bank, a.address[13:0]};
        end
      end else if (a.address[15:13] == RAM_WINDOW_TAG) begin
        offset  = (int'(a.address) - 32'hA000) % RAM_BYTES_PER_BANK;
        sel     = ram_bank;
        ram_sel = 0;
        r.target = TGT_CART_RAM;
        if (kind == KIND_MBC1) begin
          ram_sel = sel[1:0];
        end else if (kind == KIND_MBC3) begin
          if (sel < 4'd4) begin
            ram_sel = sel;
          end else if (sel >= RTC_SEL_FIRST && sel <= RTC_SEL_LAST) begin
            r.target    = TGT_RTC;
            r.rtc_index = 3'(sel - RTC_SEL_FIRST);
          end else begin
            r.target = TGT_NONE;
          end
        end
        if (r.target == TGT_CART_RAM)
          r.ram_address = 15'((ram_sel * RAM_BYTES_PER_BANK + offset) & 32'h7FFF);
        if (a.action && (r.target == TGT_CART_RAM || r.target == TGT_RTC))
          r.store_data = (kind == KIND_MBC2) ? {4'h0, a.write_data[3:0]} : a.write_data;
      end
      r.ram_enabled = ram_en;
      r.rtc_held    = (latch >= LATCH_HELD);
      expected_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      bit      bad;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result beat with nothing expected: target=%0d rom=%h ram=%h",
                   got.target, got.rom_address, got.ram_address);
        return;
      end
      exp = expected_q.pop_front();
      bad = (got.target !== exp.target) || (got.rom_address !== exp.rom_address) ||
            (got.ram_address !== exp.ram_address) || (got.rtc_index !== exp.rtc_index) ||
            (got.store_data !== exp.store_data) || (got.ram_enabled !== exp.ram_enabled) ||
            (got.rtc_held !== exp.rtc_held);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d exp tgt=%0d rom=%h ram=%h rtc=%0d st=%h en=%b lat=%b",
                   checked, exp.target, exp.rom_address, exp.ram_address, exp.rtc_index,
                   exp.store_data, exp.ram_enabled, exp.rtc_held);
          $display("       got tgt=%0d rom=%h ram=%h rtc=%0d st=%h en=%b lat=%b",
                   got.target, got.rom_address, got.ram_address, got.rtc_index,
                   got.store_data, got.ram_enabled, got.rtc_held);
        end
      end
    endfunction

    function void close_out();
      if (expected_q.size() != 0) begin
        mismatches += expected_q.size();
        $display("ERROR: %0d expected results never arrived", expected_q.size());
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic [1:0] cfg_write_data;

  cbc_access_if acc ();
  cbc_result_if res ();

  cartridge_bank_controller #(
    .RAM_BANK_BYTES(RAM_BYTES_PER_BANK)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .access        (acc),
    .result        (res)
  );

  access_scoreboard sb = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int cycle_count    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // result side: check the beat taken at this edge, then pick the next ready
  initial begin
    result_t beat;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res.valid === 1'b1 && res.ready === 1'b1) begin
        beat = '{res.target, res.rom_address, res.ram_address, res.rtc_index,
                 res.store_data, res.ram_enabled, res.rtc_held};
        sb.check_result(beat);
      end
      res.ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send(input logic act, input logic [15:0] adr, input logic [7:0] dat);
    access_t a;
    a = '{act, adr, dat};
    if ($urandom_range(99) < send_idle_pct) begin
      acc.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    acc.valid      <= 1'b1;
    acc.action     <= act;
    acc.address    <= adr;
    acc.write_data <= dat;
    do @(posedge clk); while (acc.ready !== 1'b1);
    sb.note_access(a);
    items_sent++;
  endtask

  // hold the sender until every expected result is back
  task automatic drain();
    acc.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_kind(input logic [1:0] k);
    drain();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= k;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    sb.kind = k;
  endtask

  task automatic run_random(input int count);
    int         stop_at;
    int         pick;
    logic [7:0] dat;
    logic [15:0] adr;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 22) begin
        send(1'b0, 16'($urandom_range(16'h7FFF)), 8'($urandom));
      end else if (pick < 40) begin
        send(1'($urandom), 16'($urandom_range(16'hBFFF, 16'hA000)), 8'($urandom));
      end else if (pick < 80) begin
        case ($urandom_range(7))
          0:       dat = 8'h00;
          1:       dat = 8'h01;
          2:       dat = {4'($urandom), RAM_ENABLE_KEY};
          3:       dat = 8'($urandom_range(3));
          4:       dat = 8'($urandom_range(12, 8));
          default: dat = 8'($urandom);
        endcase
        send(1'b1, 16'($urandom_range(16'h7FFF)), dat);
      end else if (pick < 90) begin
        // latch pair: 00 then mostly 01
        adr = 16'($urandom_range(16'h7FFF, 16'h6000));
        send(1'b1, adr, 8'h00);
        dat = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h01;
        send(1'b1, 16'($urandom_range(16'h7FFF, 16'h6000)), dat);
      end else begin
        send(1'($urandom), 16'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    int kind_plan[7];
    int profile_plan[7];
    kind_plan      = '{1, 3, 2, 0, 3, 1, 2};
    profile_plan   = '{0, 0, 1, 1, 2, 2, 2};
    rst            <= 1'b1;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= KIND_ROM_ONLY;
    acc.valid      <= 1'b0;
    acc.action     <= 1'b0;
    acc.address    <= 16'h0000;
    acc.write_data <= 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners, no idling on the sender
    set_kind(KIND_ROM_ONLY);
    send(1'b0, 16'h0000, 8'h00);
    send(1'b0, 16'h7FFF, 8'hFF);
    send(1'b1, 16'h2000, 8'h05);
    send(1'b1, 16'hA000, 8'hFF);
    send(1'b0, 16'hC000, 8'h00);

    set_kind(KIND_MBC1);
    send(1'b1, 16'h1FFF, 8'h0A);
    send(1'b1, 16'h2000, 8'h00);
    send(1'b1, 16'h4000, 8'h03);
    send(1'b0, 16'h7FFF, 8'h00);
    send(1'b1, 16'h6000, 8'h01);
    send(1'b1, 16'h5FFF, 8'h03);
    send(1'b1, 16'hBFFF, 8'hFF);
    send(1'b1, 16'h7FFF, 8'h00);

    set_kind(KIND_MBC2);
    send(1'b1, 16'h0100, 8'h0A);
    send(1'b1, 16'h0000, 8'h1A);
    send(1'b1, 16'h2000, 8'h03);
    send(1'b1, 16'h2100, 8'h00);
    send(1'b1, 16'h3FFF, 8'hFF);
    send(1'b0, 16'h7FFF, 8'h00);
    send(1'b1, 16'hA1FF, 8'hFF);
    send(1'b1, 16'h4000, 8'h01);

    set_kind(KIND_MBC3);
    send(1'b1, 16'h2000, 8'h00);
    send(1'b0, 16'h7FFF, 8'h00);
    send(1'b1, 16'h4000, 8'h0C);
    send(1'b1, 16'hBFFF, 8'h5A);
    send(1'b1, 16'h4000, 8'h0D);
    send(1'b0, 16'hA000, 8'h00);
    send(1'b1, 16'h6000, 8'h00);
    send(1'b1, 16'h6000, 8'h05);
    send(1'b1, 16'h6000, 8'h00);
    send(1'b1, 16'h7FFF, 8'h01);
    send(1'b1, 16'h6000, 8'h00);
    send(1'b1, 16'h6000, 8'h07);

    for (int p = 0; p < 7; p++) begin
      set_kind(2'(kind_plan[p]));
      case (profile_plan[p])
        0: begin
          send_idle_pct  = 8;
          recv_stall_pct = 61;
        end
        1: begin
          send_idle_pct  = 61;
          recv_stall_pct = 8;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      run_random(120);
    end

    drain();
    repeat (8) @(posedge clk);
    sb.close_out();
    $display("Covered %0d access beats across all four controller kinds, %0d results checked,",
             items_sent, sb.checked);
    $display("with sender and receiver stalls in both directions and %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
